// ===== design/q2e_pkg.sv =====
// Shared constants, types and the arctangent table for the quaternion to Euler angle pipeline.
// No dependencies.
package q2e_pkg;

    localparam int QW         = 16;
    localparam int ROLL_W     = 16;
    localparam int PITCH_W    = 15;
    localparam int YAW_W      = 16;
    localparam int PROD_W     = 32;
    localparam int ARG_W      = 36;
    localparam int S_W        = 30;
    localparam int SQ_W       = 57;
    localparam int ROOT_W     = 29;
    localparam int ROOT_STEPS = 29;
    localparam int XY_W       = 38;
    localparam int Z_W        = 32;
    localparam int ZM_W       = 40;
    localparam int CD_W       = 16;
    localparam int ANG_SHIFT  = 20;
    localparam int TABLE_LEN  = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [Z_W-1:0]   ANG_180 = 32'sd188743680;
    localparam logic signed [ARG_W-1:0] Q28_ONE = 36'sd268435456;
    localparam logic [SQ_W-1:0]         Q56_ONE = 57'd1 << 56;
    localparam logic signed [CD_W-1:0]  CD_MAX  = 16'sd18000;
    localparam logic signed [CD_W-1:0]  CD_MIN  = -16'sd18000;
    localparam logic signed [CD_W-1:0]  PITCH_MAX = 16'sd9000;
    localparam logic signed [CD_W-1:0]  PITCH_MIN = -16'sd9000;
    localparam logic signed [CD_W:0]    FULL_TURN = 17'sd36000;

    typedef logic signed [Z_W-1:0] angle_t;

    function automatic angle_t atan_entry(input int idx);
        angle_t tab [TABLE_LEN];
        tab = '{32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
                32'sd3750058, 32'sd1876857, 32'sd938658, 32'sd469357,
                32'sd234682, 32'sd117342, 32'sd58671, 32'sd29335,
                32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
                32'sd917, 32'sd458, 32'sd229, 32'sd115,
                32'sd57, 32'sd29, 32'sd14, 32'sd7};
        return tab[idx];
    endfunction

endpackage

// ===== design/q2e_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on q2e_pkg.
module q2e_isqrt import q2e_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [SQ_W-1:0]   val,
    output logic [ROOT_W-1:0] root
);

    logic [SQ_W:0] v_reg [1:ROOT_STEPS];
    logic [SQ_W:0] r_reg [1:ROOT_STEPS];

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
        localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (56 - 2 * k);
        logic [SQ_W:0] v_cur;
        logic [SQ_W:0] r_cur;
        logic [SQ_W:0] trial;
        logic [SQ_W:0] v_next;
        logic [SQ_W:0] r_next;

        if (k == 0) begin : g_first
            assign v_cur = {1'b0, val};
            assign r_cur = '0;
        end else begin : g_rest
            assign v_cur = v_reg[k];
            assign r_cur = r_reg[k];
        end

        always_comb begin
            trial = r_cur + BIT;
            if (v_cur >= trial) begin
                v_next = v_cur - trial;
                r_next = (r_cur >> 1) + BIT;
            end else begin
                v_next = v_cur;
                r_next = r_cur >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[k+1] <= v_next;
                r_reg[k+1] <= r_next;
            end
        end
    end

    assign root = r_reg[ROOT_STEPS][ROOT_W-1:0];

endmodule

// ===== design/q2e_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) in hundredths of a degree, saturated to a half turn.
// Depends on q2e_pkg.
module q2e_cordic import q2e_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [XY_W-1:0] y_in,
    output logic signed [CD_W-1:0] angle
);

    localparam int N = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN :
                       ((CORDIC_STEPS < 0) ? 0 : CORDIC_STEPS);

    logic signed [XY_W-1:0] x_reg [0:N];
    logic signed [XY_W-1:0] y_reg [0:N];
    angle_t                 z_reg [0:N];
    logic                   zero_reg [0:N];
    logic signed [ZM_W-1:0] zm_reg;
    logic                   zm_zero_reg;
    logic signed [CD_W-1:0] angle_reg;
    logic signed [ZM_W-1:0] cd_full;
    logic signed [CD_W-1:0] angle_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0) begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= (y_in >= 0) ? ANG_180 : -ANG_180;
            end else begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        localparam angle_t A = atan_entry(i);
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + A;
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - A;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zm_reg      <= ZM_W'(z_reg[N]) * 40'sd100 + (40'sd1 <<< (ANG_SHIFT - 1));
            zm_zero_reg <= zero_reg[N];
        end
    end

    always_comb begin
        cd_full = zm_reg >>> ANG_SHIFT;
        if (zm_zero_reg) begin
            angle_next = '0;
        end else if (cd_full > ZM_W'(CD_MAX)) begin
            angle_next = CD_MAX;
        end else if (cd_full < ZM_W'(CD_MIN)) begin
            angle_next = CD_MIN;
        end else begin
            angle_next = cd_full[CD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// ===== design/quaternion_to_euler_angles.sv =====
// Quaternion to roll, pitch and yaw. The pipeline runs through products, arguments, square,
// radicand, a 29-stage square root, the CORDIC stages and rounding.
// Throughput is one word per cycle; the whole pipeline holds only while the output word waits.
// Reset (aresetn, synchronous, active low) clears the valid bits; data registers keep their value.
// Depends on q2e_pkg, q2e_isqrt and q2e_cordic.
module quaternion_to_euler_angles import q2e_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [QW-1:0]       s_quat_i,
    input  logic signed [QW-1:0]       s_quat_j,
    input  logic signed [QW-1:0]       s_quat_k,
    input  logic signed [QW-1:0]       s_quat_real,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [ROLL_W-1:0]   m_roll_angle,
    output logic signed [PITCH_W-1:0]  m_pitch_angle,
    output logic [YAW_W-1:0]           m_yaw_angle
);

    localparam int N = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN :
                       ((CORDIC_STEPS < 0) ? 0 : CORDIC_STEPS);
    localparam int VLD_LEN = 4 + ROOT_STEPS + N + 3;

    logic en;
    logic [VLD_LEN-1:0] vld_reg;
    logic out_valid_reg;

    logic signed [PROD_W-1:0] p_ri_reg, p_jk_reg, p_ii_reg, p_jj_reg;
    logic signed [PROD_W-1:0] p_rk_reg, p_ij_reg, p_kk_reg, p_rj_reg, p_ki_reg;

    logic signed [ARG_W-1:0] roll_y_next, roll_x_next, yaw_y_next, yaw_x_next, s_full;
    logic signed [S_W-1:0]   s_next;

    logic signed [ARG_W-1:0] roll_y2_reg, roll_x2_reg, yaw_y2_reg, yaw_x2_reg;
    logic signed [S_W-1:0]   s2_reg;
    logic signed [ARG_W-1:0] roll_y3_reg, roll_x3_reg, yaw_y3_reg, yaw_x3_reg;
    logic signed [S_W-1:0]   s3_reg;
    logic [SQ_W-1:0]         sq3_reg;
    logic signed [ARG_W-1:0] roll_y4_reg, roll_x4_reg, yaw_y4_reg, yaw_x4_reg;
    logic signed [S_W-1:0]   s4_reg;
    logic [SQ_W-1:0]         rad4_reg;

    logic signed [ARG_W-1:0] dl_roll_y_reg [0:ROOT_STEPS-1];
    logic signed [ARG_W-1:0] dl_roll_x_reg [0:ROOT_STEPS-1];
    logic signed [ARG_W-1:0] dl_yaw_y_reg  [0:ROOT_STEPS-1];
    logic signed [ARG_W-1:0] dl_yaw_x_reg  [0:ROOT_STEPS-1];
    logic signed [S_W-1:0]   dl_s_reg      [0:ROOT_STEPS-1];

    logic [ROOT_W-1:0]       root;
    logic signed [CD_W-1:0]  roll_cd, pitch_cd, yaw_cd;
    logic signed [CD_W-1:0]  pitch_sat;
    logic signed [CD_W:0]    yaw_wrap;
    logic [YAW_W-1:0]        yaw_next;

    logic signed [ROLL_W-1:0]  roll_out_reg;
    logic signed [PITCH_W-1:0] pitch_out_reg;
    logic [YAW_W-1:0]          yaw_out_reg;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en && aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[VLD_LEN-2:0], s_valid};
            out_valid_reg <= vld_reg[VLD_LEN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_ri_reg <= s_quat_real * s_quat_i;
            p_jk_reg <= s_quat_j * s_quat_k;
            p_ii_reg <= s_quat_i * s_quat_i;
            p_jj_reg <= s_quat_j * s_quat_j;
            p_rk_reg <= s_quat_real * s_quat_k;
            p_ij_reg <= s_quat_i * s_quat_j;
            p_kk_reg <= s_quat_k * s_quat_k;
            p_rj_reg <= s_quat_real * s_quat_j;
            p_ki_reg <= s_quat_k * s_quat_i;
        end
    end

    always_comb begin
        roll_y_next = (ARG_W'(p_ri_reg) + ARG_W'(p_jk_reg)) <<< 1;
        roll_x_next = Q28_ONE - ((ARG_W'(p_ii_reg) + ARG_W'(p_jj_reg)) <<< 1);
        yaw_y_next  = (ARG_W'(p_rk_reg) + ARG_W'(p_ij_reg)) <<< 1;
        yaw_x_next  = Q28_ONE - ((ARG_W'(p_jj_reg) + ARG_W'(p_kk_reg)) <<< 1);
        s_full      = (ARG_W'(p_rj_reg) - ARG_W'(p_ki_reg)) <<< 1;
        if (s_full > Q28_ONE) begin
            s_next = S_W'(Q28_ONE);
        end else if (s_full < -Q28_ONE) begin
            s_next = S_W'(-Q28_ONE);
        end else begin
            s_next = s_full[S_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            roll_y2_reg <= roll_y_next;
            roll_x2_reg <= roll_x_next;
            yaw_y2_reg  <= yaw_y_next;
            yaw_x2_reg  <= yaw_x_next;
            s2_reg      <= s_next;

            roll_y3_reg <= roll_y2_reg;
            roll_x3_reg <= roll_x2_reg;
            yaw_y3_reg  <= yaw_y2_reg;
            yaw_x3_reg  <= yaw_x2_reg;
            s3_reg      <= s2_reg;
            sq3_reg     <= SQ_W'(s2_reg * s2_reg);

            roll_y4_reg <= roll_y3_reg;
            roll_x4_reg <= roll_x3_reg;
            yaw_y4_reg  <= yaw_y3_reg;
            yaw_x4_reg  <= yaw_x3_reg;
            s4_reg      <= s3_reg;
            rad4_reg    <= Q56_ONE - sq3_reg;

            dl_roll_y_reg[0] <= roll_y4_reg;
            dl_roll_x_reg[0] <= roll_x4_reg;
            dl_yaw_y_reg[0]  <= yaw_y4_reg;
            dl_yaw_x_reg[0]  <= yaw_x4_reg;
            dl_s_reg[0]      <= s4_reg;
            for (int d = 1; d < ROOT_STEPS; d++) begin
                dl_roll_y_reg[d] <= dl_roll_y_reg[d-1];
                dl_roll_x_reg[d] <= dl_roll_x_reg[d-1];
                dl_yaw_y_reg[d]  <= dl_yaw_y_reg[d-1];
                dl_yaw_x_reg[d]  <= dl_yaw_x_reg[d-1];
                dl_s_reg[d]      <= dl_s_reg[d-1];
            end
        end
    end

    q2e_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .val  (rad4_reg),
        .root (root)
    );

    q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .aclk  (aclk),
        .en    (en),
        .x_in  (XY_W'(dl_roll_x_reg[ROOT_STEPS-1])),
        .y_in  (XY_W'(dl_roll_y_reg[ROOT_STEPS-1])),
        .angle (roll_cd)
    );

    q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .aclk  (aclk),
        .en    (en),
        .x_in  ($signed({{(XY_W-ROOT_W){1'b0}}, root})),
        .y_in  (XY_W'(dl_s_reg[ROOT_STEPS-1])),
        .angle (pitch_cd)
    );

    q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .aclk  (aclk),
        .en    (en),
        .x_in  (XY_W'(dl_yaw_x_reg[ROOT_STEPS-1])),
        .y_in  (XY_W'(dl_yaw_y_reg[ROOT_STEPS-1])),
        .angle (yaw_cd)
    );

    always_comb begin
        if (pitch_cd > PITCH_MAX) begin
            pitch_sat = PITCH_MAX;
        end else if (pitch_cd < PITCH_MIN) begin
            pitch_sat = PITCH_MIN;
        end else begin
            pitch_sat = pitch_cd;
        end
        yaw_wrap = (yaw_cd < 0) ? ((CD_W+1)'(yaw_cd) + FULL_TURN) : (CD_W+1)'(yaw_cd);
        yaw_next = (yaw_wrap >= FULL_TURN) ? '0 : yaw_wrap[YAW_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            roll_out_reg  <= roll_cd;
            pitch_out_reg <= pitch_sat[PITCH_W-1:0];
            yaw_out_reg   <= yaw_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_roll_angle  = roll_out_reg;
    assign m_pitch_angle = pitch_out_reg;
    assign m_yaw_angle   = yaw_out_reg;

endmodule

// ===== design/q2e_checker.sv =====
// Port-level checks for the quaternion to Euler angle pipeline, bound to the top level.
// Depends on q2e_pkg and quaternion_to_euler_angles.
module q2e_checker import q2e_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [ROLL_W-1:0]  m_roll_angle,
    input logic signed [PITCH_W-1:0] m_pitch_angle,
    input logic [YAW_W-1:0]          m_yaw_angle
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Output word valid right after reset.");

    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("Input ready does not follow the output register state.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_roll_angle)
            && $stable(m_pitch_angle) && $stable(m_yaw_angle))
        else $error("Stalled output word changed.");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_yaw_angle < 16'd36000
            && m_roll_angle <= 16'sd18000 && m_roll_angle >= -16'sd18000
            && m_pitch_angle <= 15'sd9000 && m_pitch_angle >= -15'sd9000)
        else $error("Output angle out of range.");

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_roll_angle  (m_roll_angle),
    .m_pitch_angle (m_pitch_angle),
    .m_yaw_angle   (m_yaw_angle)
);
